// File: design/jet_pkg.sv
// Shared types and constants for the escape-time block.
package jet_pkg;

  localparam int FRAC_BITS_DEF = 28;
  localparam int ITER_CAP_DEF  = 255;

  localparam int ZW   = 32;
  localparam int PW   = 64;
  localparam int CNTW = 8;

  localparam logic [1:0] REG_C_REAL   = 2'd0;
  localparam logic [1:0] REG_C_IMAG   = 2'd1;
  localparam logic [1:0] REG_MAX_ITER = 2'd2;

  localparam logic [CNTW-1:0] MAX_ITER_RST = 8'd64;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_SUM,
    ST_UPD,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic mul;
    logic sum;
    logic upd;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic cont;
  } status_t;

endpackage

// File: design/julia_escape_time_top.sv
// Top level of the Julia-set escape-time counter with its register port.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one start point per beat:
//   z_real and z_imag, signed Q4.28. Output channel (out_valid / out_stall)
//   carries one beat per point: iteration_count, the number of z = z*z + c
//   steps done before |z| > 2 or the limit min(max_iterations, ITER_CAP).
//   The constant c and the limit sit in the APB registers: c_real at 0x0,
//   c_imag at 0x4, max_iterations at 0x8. Write them only while idle.
//
// Timing: one point at a time. Each iteration steps through multiply,
//   escape test / difference and update of z, an order set by the registered
//   32x32 multipliers and the dependent update that follows. After the last
//   iteration the count is loaded into the output register; only then is
//   the next point taken.
//   The result sits in an output register, so a new point is accepted
//   while the previous result still waits; if the receiver stalls, the
//   block holds the next finished count until the register frees up.
// Reset: synchronous, active high; clears the controller and out_valid and
//   restores c = 0 and max_iterations = 64.
module julia_escape_time_top #(
  parameter int FRAC_BITS = jet_pkg::FRAC_BITS_DEF,
  parameter int ITER_CAP  = jet_pkg::ITER_CAP_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  // point in
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic signed [jet_pkg::ZW-1:0]    z_real,
  input  logic signed [jet_pkg::ZW-1:0]    z_imag,
  // count out
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic        [jet_pkg::CNTW-1:0]  iteration_count,
  // register port
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic        [3:0]                paddr,
  input  logic        [31:0]               pwdata,
  output logic        [31:0]               prdata,
  output logic                             pready
);

  logic signed [jet_pkg::ZW-1:0]   c_real, c_imag;
  logic        [jet_pkg::CNTW-1:0] max_iterations;
  logic                            cfg_wr;
  logic        [1:0]               reg_idx;

  jet_pkg::cmd_t    cmd;
  jet_pkg::status_t status;

  // Register file: word-addressed, low address bits ignored.
  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_real         <= '0;
      c_imag         <= '0;
      max_iterations <= jet_pkg::MAX_ITER_RST;
    end else if (cfg_wr) begin
      case (reg_idx)
        jet_pkg::REG_C_REAL:   c_real         <= pwdata;
        jet_pkg::REG_C_IMAG:   c_imag         <= pwdata;
        jet_pkg::REG_MAX_ITER: max_iterations <= pwdata[jet_pkg::CNTW-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      jet_pkg::REG_C_REAL:   prdata = c_real;
      jet_pkg::REG_C_IMAG:   prdata = c_imag;
      jet_pkg::REG_MAX_ITER: prdata = {{(32 - jet_pkg::CNTW){1'b0}}, max_iterations};
      default:               prdata = '0;
    endcase
  end

  // Controller: accepts a point in IDLE, steps the iteration, loads the result.
  jet_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  // Datapath: z registers, squares, escape test, saturating update, counter.
  jet_datapath #(
    .FRAC_BITS (FRAC_BITS),
    .ITER_CAP  (ITER_CAP)
  ) u_dp (
    .clk             (clk),
    .cmd             (cmd),
    .z_real          (z_real),
    .z_imag          (z_imag),
    .c_real          (c_real),
    .c_imag          (c_imag),
    .max_iterations  (max_iterations),
    .status          (status),
    .iteration_count (iteration_count)
  );

endmodule

// File: design/jet_ctrl.sv
// Sequencer for the escape-time iteration and the output beat.
module jet_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  output logic            out_valid,
  input  logic            out_stall,
  input  jet_pkg::status_t status,
  output jet_pkg::cmd_t   cmd
);

  jet_pkg::state_t state, state_next;
  logic out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= jet_pkg::ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    case (state)
      jet_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = jet_pkg::ST_MUL;
        end
      end
      jet_pkg::ST_MUL: begin
        cmd.mul    = 1'b1;
        state_next = jet_pkg::ST_SUM;
      end
      jet_pkg::ST_SUM: begin
        cmd.sum    = 1'b1;
        state_next = jet_pkg::ST_UPD;
      end
      jet_pkg::ST_UPD: begin
        if (status.cont) begin
          cmd.upd    = 1'b1;
          state_next = jet_pkg::ST_MUL;
        end else begin
          state_next = jet_pkg::ST_DONE;
        end
      end
      jet_pkg::ST_DONE: begin
        if (!out_valid || !out_stall) begin
          cmd.out_load = 1'b1;
          state_next   = jet_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = jet_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.out_load) begin
      out_valid_next = 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

endmodule

// File: design/jet_datapath.sv
// Complex square, escape test, update of z and the iteration counter.
module jet_datapath #(
  parameter int FRAC_BITS = jet_pkg::FRAC_BITS_DEF,
  parameter int ITER_CAP  = jet_pkg::ITER_CAP_DEF
) (
  input  logic                             clk,
  input  jet_pkg::cmd_t                    cmd,
  input  logic signed [jet_pkg::ZW-1:0]    z_real,
  input  logic signed [jet_pkg::ZW-1:0]    z_imag,
  input  logic signed [jet_pkg::ZW-1:0]    c_real,
  input  logic signed [jet_pkg::ZW-1:0]    c_imag,
  input  logic        [jet_pkg::CNTW-1:0]  max_iterations,
  output jet_pkg::status_t                 status,
  output logic        [jet_pkg::CNTW-1:0]  iteration_count
);

  localparam int ZW   = jet_pkg::ZW;
  localparam int PW   = jet_pkg::PW;
  localparam int CNTW = jet_pkg::CNTW;
  localparam int ESC_SH = 2 * FRAC_BITS + 2;
  localparam bit ESC_OPEN = (ESC_SH >= PW);
  localparam logic [PW-1:0] ESC_LIM = ESC_OPEN ? '0 : (64'd1 << ESC_SH);

  logic signed [ZW-1:0]   re, im;
  logic signed [PW-1:0]   sq_re, sq_im, pr, diff;
  logic        [CNTW-1:0] count, limit, limit_in;
  logic                   cont;

  logic        [PW-1:0]   mag;
  logic                   in_circle;
  logic signed [PW-1:0]   c_re_ext, c_im_ext, nre, nim;
  logic signed [ZW-1:0]   nre_sat, nim_sat;

  // limit = min(max_iterations, cap)
  always_comb begin
    if (32'(max_iterations) > ITER_CAP) begin
      limit_in = CNTW'(ITER_CAP);
    end else begin
      limit_in = max_iterations;
    end
  end

  assign mag       = sq_re + sq_im;
  assign in_circle = ESC_OPEN || (mag <= ESC_LIM);

  assign c_re_ext = PW'(c_real);
  assign c_im_ext = PW'(c_imag);
  assign nre = (diff >>> FRAC_BITS) + c_re_ext;
  assign nim = (pr >>> (FRAC_BITS - 1)) + c_im_ext;

  // saturate to signed 32 bits
  always_comb begin
    if (nre[PW-1:ZW-1] == '0 || nre[PW-1:ZW-1] == '1) begin
      nre_sat = nre[ZW-1:0];
    end else begin
      nre_sat = nre[PW-1] ? {1'b1, {(ZW-1){1'b0}}} : {1'b0, {(ZW-1){1'b1}}};
    end
    if (nim[PW-1:ZW-1] == '0 || nim[PW-1:ZW-1] == '1) begin
      nim_sat = nim[ZW-1:0];
    end else begin
      nim_sat = nim[PW-1] ? {1'b1, {(ZW-1){1'b0}}} : {1'b0, {(ZW-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      re    <= z_real;
      im    <= z_imag;
      count <= '0;
      limit <= limit_in;
    end
    if (cmd.mul) begin
      sq_re <= re * re;
      sq_im <= im * im;
      pr    <= re * im;
    end
    if (cmd.sum) begin
      diff <= sq_re - sq_im;
      cont <= (count < limit) && in_circle;
    end
    if (cmd.upd) begin
      re    <= nre_sat;
      im    <= nim_sat;
      count <= count + 1'b1;
    end
    if (cmd.out_load) begin
      iteration_count <= count;
    end
  end

  assign status.cont = cont;

endmodule

// File: sim/tb_julia_escape_time_top.sv
// Self-checking testbench for the Julia-set escape-time counter top level.
`timescale 1ns / 1ps

module tb_julia_escape_time_top;

  localparam int ZW   = jet_pkg::ZW;
  localparam int CNTW = jet_pkg::CNTW;

  // fixed-point and limit settings the block is built with
  localparam int FRAC = jet_pkg::FRAC_BITS_DEF;
  localparam int CAP  = jet_pkg::ITER_CAP_DEF;

  // address slot past the end of the register list, must be ignored
  localparam logic [1:0] REG_SPARE = 2'd3;

  // Q4.28 landmarks
  localparam logic signed [ZW-1:0] Q_ONE = 32'sh1000_0000;
  localparam logic signed [ZW-1:0] Q_TWO = 32'sh2000_0000;
  localparam logic signed [ZW-1:0] Z_MIN = 32'sh8000_0000;
  localparam logic signed [ZW-1:0] Z_MAX = 32'sh7FFF_FFFF;

  // drain wait: covers the worst point, rounded up
  localparam int DRAIN_CYCLES  = 800;
  localparam int RANDOM_POINTS = 1250;
  localparam int HOLD_CYCLES   = 3000;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_TOGGLE
  } stall_mode_t;

  // one directed beat: register setting it runs under, start point, and
  // the count when it is obvious by inspection
  typedef struct packed {
    logic signed [ZW-1:0]   cre;
    logic signed [ZW-1:0]   cim;
    logic        [CNTW-1:0] lim;
    logic signed [ZW-1:0]   zr;
    logic signed [ZW-1:0]   zi;
    logic                   known;
    logic        [CNTW-1:0] cnt;
  } point_row_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic signed [ZW-1:0]   z_real = '0;
  logic signed [ZW-1:0]   z_imag = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic        [CNTW-1:0] iteration_count;
  logic                   psel = 1'b0;
  logic                   penable = 1'b0;
  logic                   pwrite = 1'b0;
  logic        [3:0]      paddr = '0;
  logic        [31:0]     pwdata = '0;
  logic        [31:0]     prdata;
  logic                   pready;

  julia_escape_time_top dut (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .z_real          (z_real),
    .z_imag          (z_imag),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .iteration_count (iteration_count),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  // 12 ns period
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Shadow copy of the register file, kept in step with every write.
  logic signed [ZW-1:0]   shadow_c_re  = '0;
  logic signed [ZW-1:0]   shadow_c_im  = '0;
  logic        [CNTW-1:0] shadow_max   = jet_pkg::MAX_ITER_RST;

  logic [CNTW-1:0] pending_counts[$];
  point_row_t      directed_rows[$];

  int error_count    = 0;
  int points_sent    = 0;
  int counts_checked = 0;
  int settings_used  = 0;
  int burst_left     = 4;
  bit hold_req       = 1'b0;

  // ---------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------

  function automatic longint clamp_z(input longint v);
    if (v > longint'(Z_MAX)) return longint'(Z_MAX);
    if (v < longint'(Z_MIN)) return longint'(Z_MIN);
    return v;
  endfunction

  // Escape-time count for one start point under the shadow registers.
  // Squares are exact 64-bit; new z is floored back to Q4.28, c added,
  // then each part clamped to 32 bits.
  function automatic logic [CNTW-1:0] escape_count(input logic signed [ZW-1:0] zr0,
                                                   input logic signed [ZW-1:0] zi0);
    longint          re;
    longint          im;
    longint          rr;
    longint          ii;
    longint          nre;
    longint          nim;
    longint unsigned mag;
    longint unsigned bound;
    int unsigned     lim;
    int unsigned     n;
    re = longint'(zr0);
    im = longint'(zi0);
    lim = 32'(shadow_max);
    if (lim > CAP) lim = CAP;
    // 4.0 in the squared format; if it needs 64 bits nothing can escape
    bound = (2 * FRAC + 2 >= 64) ? 64'hFFFF_FFFF_FFFF_FFFF : (64'd1 << (2 * FRAC + 2));
    n = 0;
    while (n < lim) begin
      rr = re * re;
      ii = im * im;
      mag = longint'(rr) + longint'(ii);
      if (mag > bound) break;
      nre = ((rr - ii) >>> FRAC) + longint'(shadow_c_re);
      nim = ((re * im) >>> (FRAC - 1)) + longint'(shadow_c_im);
      re = clamp_z(nre);
      im = clamp_z(nim);
      n++;
    end
    return n[CNTW-1:0];
  endfunction

  task automatic flag_mismatch(input string msg);
    $display("[%0t] MISMATCH: %s", $realtime, msg);
    error_count++;
  endtask

  // ---------------------------------------------------------------------
  // Result side: stall pattern and checker
  // ---------------------------------------------------------------------

  stall_mode_t stall_mode = STALL_NONE;
  int          mode_left  = 0;
  int          hold_left  = 0;
  bit          hold_done  = 1'b0;

  // Receiver stalls on a pattern that changes at random intervals.
  // Once, on request, it holds off for a long stretch so the output
  // register and the finished count behind it back up into in_stall.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        if (mode_left == 0) begin
          stall_mode = stall_mode_t'($urandom_range(0, 3));
          mode_left  = $urandom_range(40, 400);
        end else begin
          mode_left--;
        end
        case (stall_mode)
          STALL_NONE:   out_stall <= 1'b0;
          STALL_LIGHT:  out_stall <= ($urandom_range(0, 3) == 0);
          STALL_HEAVY:  out_stall <= ($urandom_range(0, 3) != 0);
          STALL_TOGGLE: out_stall <= ~out_stall;
          default:      out_stall <= 1'b0;
        endcase
      end
    end
  end

  // Every accepted count beat is matched against the oldest expectation.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_counts.size() == 0) begin
        flag_mismatch($sformatf("count %0d with nothing expected", iteration_count));
      end else begin
        if (iteration_count !== pending_counts[0])
          flag_mismatch($sformatf("iteration_count %0d, expected %0d",
                                  iteration_count, pending_counts[0]));
        void'(pending_counts.pop_front());
        counts_checked++;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Point side
  // ---------------------------------------------------------------------

  // Offer one start point and hold it until taken. Sender runs in bursts;
  // at the end of a burst valid drops for a random gap.
  task automatic offer_point(input logic signed [ZW-1:0] zr,
                             input logic signed [ZW-1:0] zi,
                             input logic known,
                             input logic [CNTW-1:0] cnt);
    z_real   <= zr;
    z_imag   <= zi;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_counts.push_back(known ? cnt : escape_count(zr, zi));
    points_sent++;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = $urandom_range(1, 12);
    end
  endtask

  // Stop offering and wait until every expected count has come back.
  task automatic quiesce();
    in_valid <= 1'b0;
    while (pending_counts.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------
  // Register port
  // ---------------------------------------------------------------------

  // Setup, access, then an idle phase so back-to-back calls never
  // assign psel twice in one step. Shadow follows the register map.
  task automatic apb_write(input logic [1:0] idx, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      jet_pkg::REG_C_REAL:   shadow_c_re = data;
      jet_pkg::REG_C_IMAG:   shadow_c_im = data;
      jet_pkg::REG_MAX_ITER: shadow_max  = data[CNTW-1:0];
      default:      ;
    endcase
    @(posedge clk);
  endtask

  task automatic apb_read(input logic [1:0] idx, output logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    data = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic check_readback();
    logic [31:0] rd;
    apb_read(jet_pkg::REG_C_REAL, rd);
    if (rd !== shadow_c_re) flag_mismatch($sformatf("c_real reads %h, expected %h",
                                                    rd, shadow_c_re));
    apb_read(jet_pkg::REG_C_IMAG, rd);
    if (rd !== shadow_c_im) flag_mismatch($sformatf("c_imag reads %h, expected %h",
                                                    rd, shadow_c_im));
    apb_read(jet_pkg::REG_MAX_ITER, rd);
    if (rd[CNTW-1:0] !== shadow_max)
      flag_mismatch($sformatf("max_iterations reads %0d, expected %0d",
                              rd[CNTW-1:0], shadow_max));
  endtask

  // Block must be idle when this is called.
  task automatic program_constant(input logic signed [ZW-1:0] cre,
                                  input logic signed [ZW-1:0] cim,
                                  input logic [31:0] lim_word);
    apb_write(jet_pkg::REG_C_REAL, cre);
    apb_write(jet_pkg::REG_C_IMAG, cim);
    apb_write(jet_pkg::REG_MAX_ITER, lim_word);
    check_readback();
    settings_used++;
  endtask

  task automatic add_row(input logic signed [ZW-1:0] cre, input logic signed [ZW-1:0] cim,
                         input logic [CNTW-1:0] lim,
                         input logic signed [ZW-1:0] zr, input logic signed [ZW-1:0] zi,
                         input logic known, input logic [CNTW-1:0] cnt);
    point_row_t r;
    r.cre = cre; r.cim = cim; r.lim = lim;
    r.zr = zr; r.zi = zi; r.known = known; r.cnt = cnt;
    directed_rows.push_back(r);
  endtask

  // uniform in [-2.0, 2.0] in Q4.28
  function automatic logic signed [ZW-1:0] box_coord();
    return $urandom_range(0, 32'h4000_0000) - 32'h2000_0000;
  endfunction

  function automatic logic signed [ZW-1:0] pick_extreme();
    case ($urandom_range(0, 2))
      0:       return Z_MIN;
      1:       return Z_MAX;
      default: return '0;
    endcase
  endfunction

  // ---------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------

  initial begin
    int                     phase;
    int                     batch;
    int                     sel;
    logic signed [ZW-1:0]   cre;
    logic signed [ZW-1:0]   cim;
    logic signed [ZW-1:0]   zr;
    logic signed [ZW-1:0]   zi;
    logic        [CNTW-1:0] lim;
    int                     n_directed;

    // Reset values first: c = 0, limit 64. Orbit landmarks of z*z:
    // 0 stays put, unit points stay on the unit circle, +-2 lands on 4 and leaves next pass,
    // |z|^2 exactly 4 still counts as inside.
    add_row('0, '0, 8'd64, '0, '0, 1'b1, 8'd64);
    add_row('0, '0, 8'd64, Q_TWO, '0, 1'b1, 8'd1);
    add_row('0, '0, 8'd64, Q_TWO + 1, '0, 1'b1, 8'd0);
    add_row('0, '0, 8'd64, '0, Q_TWO, 1'b1, 8'd1);
    add_row('0, '0, 8'd64, '0, -Q_TWO, 1'b1, 8'd1);
    add_row('0, '0, 8'd64, -Q_TWO, '0, 1'b1, 8'd1);
    add_row('0, '0, 8'd64, Z_MIN, Z_MIN, 1'b1, 8'd0);
    add_row('0, '0, 8'd64, Z_MAX, Z_MAX, 1'b1, 8'd0);
    add_row('0, '0, 8'd64, Z_MAX, Z_MIN, 1'b1, 8'd0);
    add_row('0, '0, 8'd64, Q_ONE, '0, 1'b1, 8'd64);
    add_row('0, '0, 8'd64, -Q_ONE, '0, 1'b1, 8'd64);
    add_row('0, '0, 8'd64, '0, Q_ONE, 1'b1, 8'd64);
    // negative product floors toward minus infinity
    add_row('0, '0, 8'd64, 32'sd1, -32'sd1, 1'b0, '0);
    // just under |z| = 2 on the diagonal
    add_row('0, '0, 8'd64, 32'sh16A0_9E66, 32'sh16A0_9E66, 1'b0, '0);
    // zero limit: nothing iterates, even for an outside point
    add_row('0, '0, 8'd0, '0, '0, 1'b1, 8'd0);
    add_row('0, '0, 8'd0, Z_MAX, Z_MAX, 1'b1, 8'd0);
    add_row('0, '0, 8'd1, '0, '0, 1'b1, 8'd1);
    add_row('0, '0, 8'd1, Q_TWO + 1, '0, 1'b1, 8'd0);
    add_row('0, '0, 8'd255, '0, '0, 1'b1, 8'd255);
    // extreme c: first step jumps straight out; re part saturates high
    add_row(Z_MIN, Z_MIN, 8'd255, '0, '0, 1'b1, 8'd1);
    add_row(Z_MAX, Z_MAX, 8'd255, Q_TWO, '0, 1'b1, 8'd1);
    add_row(Z_MAX, Z_MAX, 8'd255, '0, '0, 1'b1, 8'd1);
    // inside the set, long orbits
    add_row(32'sh0400_0000, '0, 8'd255, '0, '0, 1'b0, '0);
    add_row(-32'sh0CCC_CCCD, 32'sh027E_F9DB, 8'd200, '0, '0, 1'b0, '0);
    add_row(-32'sh0CCC_CCCD, 32'sh027E_F9DB, 8'd200, 32'sh0199_999A, -32'sh0333_3333,
            1'b0, '0);

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    check_readback();

    // directed table; registers only change once the block has drained
    foreach (directed_rows[i]) begin
      if (directed_rows[i].cre !== shadow_c_re || directed_rows[i].cim !== shadow_c_im ||
          directed_rows[i].lim !== shadow_max) begin
        quiesce();
        program_constant(directed_rows[i].cre, directed_rows[i].cim,
                         {24'h0, directed_rows[i].lim});
      end
      offer_point(directed_rows[i].zr, directed_rows[i].zi,
                  directed_rows[i].known, directed_rows[i].cnt);
    end

    // a write past the register list must leave everything unchanged
    quiesce();
    apb_write(REG_SPARE, $urandom());
    check_readback();
    offer_point(Q_ONE, -Q_ONE, 1'b0, '0);
    n_directed = points_sent;

    // Random phases: new c and limit each phase. Mostly c near the set
    // so orbits run long, plus full-range, extreme and zero constants. Long
    // limits get short batches to keep the run bounded.
    phase = 0;
    while (points_sent < n_directed + RANDOM_POINTS) begin
      sel = $urandom_range(0, 9);
      if (sel <= 5) begin
        cre = box_coord();
        cim = box_coord();
      end else if (sel <= 7) begin
        cre = $urandom();
        cim = $urandom();
      end else if (sel == 8) begin
        cre = pick_extreme();
        cim = pick_extreme();
      end else begin
        cre = '0;
        cim = '0;
      end
      sel = $urandom_range(0, 15);
      case (sel)
        0:       lim = 8'd0;
        1:       lim = 8'd1;
        2:       lim = 8'd255;
        3:       lim = CNTW'($urandom_range(65, 254));
        4, 5, 6: lim = 8'd64;
        default: lim = CNTW'($urandom_range(2, 40));
      endcase
      batch = (lim > 64) ? 16 : 60;

      quiesce();
      // upper bits of the limit word are junk and must be dropped
      program_constant(cre, cim, ($urandom() & 32'hFFFF_FF00) | lim);

      for (int i = 0; i < batch; i++) begin
        // one long receiver hold-off while points keep coming
        if (phase == 2 && i == 4) hold_req = 1'b1;
        // one pause mid-phase until all counts are back
        if (phase == 4 && i == batch / 2) quiesce();
        sel = $urandom_range(0, 9);
        if (sel <= 6) begin
          zr = box_coord();
          zi = box_coord();
        end else if (sel == 7) begin
          // hug the escape-radius edge on either axis and sign
          zr = ($urandom_range(0, 1) ? Q_TWO : -Q_TWO) + $urandom_range(0, 8) - 4;
          zi = $urandom_range(0, 255) - 128;
          if ($urandom_range(0, 1)) begin
            zi = zr;
            zr = $urandom_range(0, 255) - 128;
          end
        end else begin
          zr = $urandom();
          zi = $urandom();
        end
        offer_point(zr, zi, 1'b0, '0);
      end
      phase++;
    end

    quiesce();
    // nothing more may come out of the block
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Summary: %0d points (%0d directed) over %0d register settings, %0d counts checked",
             points_sent, n_directed, settings_used, counts_checked);
    $display("Summary: random phases %0d, long receiver hold-off %0s", phase,
             hold_done ? "done" : "missed");
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Watchdog: worst case is ~1300 points, each at its longest, plus stalls,
  // about 15 ms; allow several times that.
  initial begin
    #80_000_000;
    $display("[%0t] timeout, %0d counts still pending", $realtime, pending_counts.size());
    $display("DONE: errors detected");
    $finish;
  end

endmodule
